// ===== rtl/core/string_intern_table_macros.svh =====
`ifndef STRING_INTERN_TABLE_MACROS_SVH
`define STRING_INTERN_TABLE_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge
`define SIT_ASSERT_NOW(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("string intern table check failed");

// Next-cycle implication, checked at each rising clock edge
`define SIT_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("string intern table check failed");

`endif

// ===== rtl/core/sit_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sit_pkg;

  localparam int LEN_W    = 7;
  localparam int ID_W     = 8;
  localparam int CNT_W    = 9;
  localparam int CHAR_W   = 8;
  localparam int OUTLEN_W = 6;

  localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;
  localparam logic [CNT_W-1:0] CAP_MIN   = 9'd2;

  typedef enum logic [1:0] {
    FN_LOOKUP = 2'd0,
    FN_INSERT = 2'd1,
    FN_READ   = 2'd2
  } func_t;

  // One queued command for the back end
  typedef struct packed {
    logic              is_read;
    logic              is_insert;
    logic              ovf;
    logic              bank;
    logic [LEN_W-1:0]  klen;
    logic [ID_W-1:0]   rid;
  } cmd_t;

  // One result word
  typedef struct packed {
    logic                valid;
    logic [ID_W-1:0]     id;
    logic [CHAR_W-1:0]   chr;
    logic [OUTLEN_W-1:0] len;
    logic                last;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LEN,
    BK_LCHK,
    BK_CMP,
    BK_MISS,
    BK_COPY,
    BK_STREAM
  } bk_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/sit_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int AW    = 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/sit_cmdq.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sit_cmdq import sit_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty,
  output logic      full
);

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // advance pointers and count
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop  ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // hold command payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  assign head  = slot_r[rp_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);

endmodule
`default_nettype wire

// ===== rtl/core/sit_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sit_front import sit_pkg::*; #(
  parameter int NAME_MAX_CHARS = 32,
  parameter int KA_W           = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [1:0]        func,
  input  wire logic [CHAR_W-1:0] key_char,
  input  wire logic              key_last,
  input  wire logic [ID_W-1:0]   read_id,
  output logic                   key_we,
  output logic      [KA_W-1:0]   key_waddr,
  output logic      [CHAR_W-1:0] key_wdata,
  output logic                   push,
  output cmd_t                   push_cmd
);

  logic [LEN_W-1:0] klen_r, klen_nxt;
  logic             ovf_r, ovf_nxt;
  logic             wbank_r, wbank_nxt;
  logic             is_key, room;
  logic [LEN_W-1:0] klen_after;
  logic             ovf_after;

  // classify the word and buffer key characters
  always_comb begin
    is_key     = accept && (func == FN_LOOKUP || func == FN_INSERT);
    room       = klen_r < LEN_W'(NAME_MAX_CHARS);
    klen_after = room ? klen_r + LEN_W'(1) : klen_r;
    ovf_after  = ovf_r | ~room;
    key_we     = is_key && room;
    key_waddr  = wbank_r ? KA_W'(NAME_MAX_CHARS) + KA_W'(klen_r) : KA_W'(klen_r);
    key_wdata  = key_char;
  end

  // hand finished names and reads to the queue
  always_comb begin
    push               = (is_key && key_last) || (accept && func == FN_READ);
    push_cmd.is_read   = (func == FN_READ);
    push_cmd.is_insert = (func == FN_INSERT);
    push_cmd.ovf       = ovf_after;
    push_cmd.bank      = wbank_r;
    push_cmd.klen      = klen_after;
    push_cmd.rid       = read_id;
  end

  // advance key state, drop it after the final character
  always_comb begin
    klen_nxt  = klen_r;
    ovf_nxt   = ovf_r;
    wbank_nxt = wbank_r;
    if (is_key) begin
      if (key_last) begin
        klen_nxt  = '0;
        ovf_nxt   = 1'b0;
        wbank_nxt = ~wbank_r;
      end else begin
        klen_nxt = klen_after;
        ovf_nxt  = ovf_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r  <= '0;
      ovf_r   <= 1'b0;
      wbank_r <= 1'b0;
    end else begin
      klen_r  <= klen_nxt;
      ovf_r   <= ovf_nxt;
      wbank_r <= wbank_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sit_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sit_back import sit_pkg::*; #(
  parameter int MAX_ENTRIES    = 256,
  parameter int NAME_MAX_CHARS = 32,
  parameter int IW             = 8,
  parameter int CA_W           = 13,
  parameter int KA_W           = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CNT_W-1:0]  cap,
  input  wire logic              q_empty,
  input  wire cmd_t              head,
  output logic                   pop,
  output res_t                   res,
  output logic      [IW-1:0]     len_raddr,
  input  wire logic [LEN_W-1:0]  len_rdata,
  output logic                   len_we,
  output logic      [IW-1:0]     len_waddr,
  output logic      [LEN_W-1:0]  len_wdata,
  output logic      [CA_W-1:0]   ch_raddr,
  input  wire logic [CHAR_W-1:0] ch_rdata,
  output logic                   ch_we,
  output logic      [CA_W-1:0]   ch_waddr,
  output logic      [CHAR_W-1:0] ch_wdata,
  output logic      [KA_W-1:0]   key_raddr,
  input  wire logic [CHAR_W-1:0] key_rdata
);

  localparam int ID_LIMIT = (MAX_ENTRIES < 256) ? MAX_ENTRIES : 256;

  bk_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] sid_r, sid_nxt;
  logic [LEN_W-1:0] ci_r, ci_nxt;
  logic             pv_r, pv_nxt;
  logic [LEN_W-1:0] rlen_r, rlen_nxt;
  logic [CNT_W-1:0] ec_r, ec_nxt;
  res_t             res_r, res_nxt;

  logic [CNT_W-1:0] eff;
  logic [CNT_W-1:0] sid_inc;
  logic             last_id, rd_bad, mism, room, key_done, rd_done;
  logic [CA_W-1:0]  ch_base;

  // shared status terms
  always_comb begin
    if (cap < CAP_MIN) begin
      eff = CAP_MIN;
    end else if (cap > CNT_W'(ID_LIMIT)) begin
      eff = CNT_W'(ID_LIMIT);
    end else begin
      eff = cap;
    end
    sid_inc  = sid_r + CNT_W'(1);
    last_id  = sid_inc >= ec_r;
    rd_bad   = (head.rid == '0) || (CNT_W'(head.rid) >= ec_r);
    mism     = pv_r && (ch_rdata != key_rdata);
    room     = ec_r < eff;
    key_done = (ci_r == head.klen);
    rd_done  = (ci_r == rlen_r);
  end

  // memory addresses
  always_comb begin
    ch_base   = CA_W'(sid_r) * CA_W'(NAME_MAX_CHARS);
    ch_raddr  = ch_base + CA_W'(ci_r);
    ch_waddr  = ch_base + CA_W'(ci_r - LEN_W'(1));
    ch_wdata  = key_rdata;
    key_raddr = head.bank ? KA_W'(NAME_MAX_CHARS) + KA_W'(ci_r) : KA_W'(ci_r);
    len_raddr = IW'(sid_r);
    len_waddr = IW'(sid_r);
    len_wdata = head.klen;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (head.is_read) begin
            state_nxt = rd_bad ? BK_IDLE : BK_LEN;
          end else if (head.ovf) begin
            state_nxt = BK_IDLE;
          end else if (ec_r <= CNT_W'(1)) begin
            state_nxt = BK_MISS;
          end else begin
            state_nxt = BK_LEN;
          end
        end
      end
      BK_LEN: state_nxt = BK_LCHK;
      BK_LCHK: begin
        if (head.is_read) begin
          state_nxt = (len_rdata == '0) ? BK_IDLE : BK_STREAM;
        end else if (len_rdata == head.klen) begin
          state_nxt = BK_CMP;
        end else begin
          state_nxt = last_id ? BK_MISS : BK_LEN;
        end
      end
      BK_CMP: begin
        if (mism) begin
          state_nxt = last_id ? BK_MISS : BK_LEN;
        end else if (key_done) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_MISS:   state_nxt = (head.is_insert && room) ? BK_COPY : BK_IDLE;
      BK_COPY:   state_nxt = (pv_r && key_done) ? BK_IDLE : BK_COPY;
      BK_STREAM: state_nxt = (pv_r && rd_done) ? BK_IDLE : BK_STREAM;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // datapath and result words
  always_comb begin
    sid_nxt  = sid_r;
    ci_nxt   = ci_r;
    pv_nxt   = pv_r;
    rlen_nxt = rlen_r;
    ec_nxt   = ec_r;
    res_nxt  = '0;
    pop      = 1'b0;
    ch_we    = 1'b0;
    len_we   = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (head.is_read) begin
            if (rd_bad) begin
              res_nxt.valid = 1'b1;
              res_nxt.last  = 1'b1;
              pop           = 1'b1;
            end else begin
              sid_nxt = CNT_W'(head.rid);
            end
          end else if (head.ovf) begin
            res_nxt.valid = 1'b1;
            res_nxt.last  = 1'b1;
            pop           = 1'b1;
          end else begin
            sid_nxt = CNT_W'(1);
          end
        end
      end
      BK_LCHK: begin
        ci_nxt = '0;
        pv_nxt = 1'b0;
        if (head.is_read) begin
          rlen_nxt = len_rdata;
          if (len_rdata == '0) begin
            res_nxt.valid = 1'b1;
            res_nxt.last  = 1'b1;
            pop           = 1'b1;
          end
        end else if (len_rdata != head.klen && !last_id) begin
          sid_nxt = sid_inc;
        end
      end
      BK_CMP: begin
        if (mism) begin
          if (!last_id) begin
            sid_nxt = sid_inc;
          end
        end else if (key_done) begin
          res_nxt.valid = 1'b1;
          res_nxt.id    = ID_W'(sid_r);
          res_nxt.last  = 1'b1;
          pop           = 1'b1;
        end else begin
          ci_nxt = ci_r + LEN_W'(1);
          pv_nxt = 1'b1;
        end
      end
      BK_MISS: begin
        ci_nxt = '0;
        pv_nxt = 1'b0;
        if (head.is_insert && room) begin
          sid_nxt = ec_r;
        end else begin
          res_nxt.valid = 1'b1;
          res_nxt.last  = 1'b1;
          pop           = 1'b1;
        end
      end
      BK_COPY: begin
        ch_we = pv_r;
        if (pv_r && key_done) begin
          len_we        = 1'b1;
          ec_nxt        = ec_r + CNT_W'(1);
          res_nxt.valid = 1'b1;
          res_nxt.id    = ID_W'(sid_r);
          res_nxt.last  = 1'b1;
          pop           = 1'b1;
        end else if (!key_done) begin
          ci_nxt = ci_r + LEN_W'(1);
          pv_nxt = 1'b1;
        end
      end
      BK_STREAM: begin
        if (pv_r) begin
          res_nxt.valid = 1'b1;
          res_nxt.id    = ID_W'(sid_r);
          res_nxt.chr   = ch_rdata;
          res_nxt.len   = OUTLEN_W'(rlen_r);
          res_nxt.last  = rd_done;
        end
        if (pv_r && rd_done) begin
          pop = 1'b1;
        end else if (!rd_done) begin
          ci_nxt = ci_r + LEN_W'(1);
          pv_nxt = 1'b1;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ec_r    <= CNT_W'(1);
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ec_r    <= ec_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sid_r  <= sid_nxt;
    ci_r   <= ci_nxt;
    pv_r   <= pv_nxt;
    rlen_r <= rlen_nxt;
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== rtl/core/string_intern_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake            Payload
// input     start / busy         in_func, in_key_char, in_key_last, in_read_id
// result    out_valid (strobe)   out_result_id, out_char, out_length, out_last
// config    cfg_we               cfg_wdata (table capacity)
//
// A non-final key character starts no search. A final character starts a linear
// search of the stored names: each stored id has its length read and checked, and
// when the lengths agree its characters are compared one by one. On a miss an
// insert copies the new name into the store if there is room. A read streams the
// stored name one character per result word, through the single name-store read port.
// busy rises while the two-entry command queue is full; results cannot stall.
// Synchronous active-low reset; stores need no clearing pass.
module string_intern_table import sit_pkg::*; #(
  parameter int MAX_ENTRIES    = 256,
  parameter int NAME_MAX_CHARS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_func,
  input  wire logic [CHAR_W-1:0]   in_key_char,
  input  wire logic                in_key_last,
  input  wire logic [ID_W-1:0]     in_read_id,
  output logic                     out_valid,
  output logic      [ID_W-1:0]     out_result_id,
  output logic      [CHAR_W-1:0]   out_char,
  output logic      [OUTLEN_W-1:0] out_length,
  output logic                     out_last,
  input  wire logic                cfg_we,
  input  wire logic [CNT_W-1:0]    cfg_wdata
);

  localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CA_W = $clog2(MAX_ENTRIES * NAME_MAX_CHARS);
  localparam int KA_W = $clog2(2 * NAME_MAX_CHARS);

  logic [CNT_W-1:0] cap_r;
  logic             accept, push, pop, q_empty, q_full;
  cmd_t             push_cmd, head;
  res_t             res;

  logic              key_we;
  logic [KA_W-1:0]   key_waddr, key_raddr;
  logic [CHAR_W-1:0] key_wdata, key_rdata;
  logic              len_we;
  logic [IW-1:0]     len_waddr, len_raddr;
  logic [LEN_W-1:0]  len_wdata, len_rdata;
  logic              ch_we;
  logic [CA_W-1:0]   ch_waddr, ch_raddr;
  logic [CHAR_W-1:0] ch_wdata, ch_rdata;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  assign accept = start && !busy;
  assign busy   = q_full;

  sit_front #(.NAME_MAX_CHARS(NAME_MAX_CHARS), .KA_W(KA_W)) u_front (
    .clk, .rst_n, .accept,
    .func(in_func), .key_char(in_key_char), .key_last(in_key_last),
    .read_id(in_read_id),
    .key_we, .key_waddr, .key_wdata, .push, .push_cmd
  );

  sit_cmdq u_cmdq (
    .clk, .rst_n, .push, .push_cmd, .pop, .head,
    .empty(q_empty), .full(q_full)
  );

  sit_back #(
    .MAX_ENTRIES(MAX_ENTRIES), .NAME_MAX_CHARS(NAME_MAX_CHARS),
    .IW(IW), .CA_W(CA_W), .KA_W(KA_W)
  ) u_back (
    .clk, .rst_n, .cap(cap_r), .q_empty, .head, .pop, .res,
    .len_raddr, .len_rdata, .len_we, .len_waddr, .len_wdata,
    .ch_raddr, .ch_rdata, .ch_we, .ch_waddr, .ch_wdata,
    .key_raddr, .key_rdata
  );

  // two key banks so the next name can fill while one is searched
  sit_ram #(.WIDTH(CHAR_W), .DEPTH(2 * NAME_MAX_CHARS), .AW(KA_W)) u_key_ram (
    .clk, .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  sit_ram #(.WIDTH(LEN_W), .DEPTH(MAX_ENTRIES), .AW(IW)) u_len_ram (
    .clk, .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
    .raddr(len_raddr), .rdata(len_rdata)
  );

  sit_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_ENTRIES * NAME_MAX_CHARS), .AW(CA_W)) u_char_ram (
    .clk, .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(ch_raddr), .rdata(ch_rdata)
  );

  assign out_valid     = res.valid;
  assign out_result_id = res.id;
  assign out_char      = res.chr;
  assign out_length    = res.len;
  assign out_last      = res.last;

endmodule
`default_nettype wire

// ===== rtl/core/sit_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "string_intern_table_macros.svh"
module sit_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [7:0] out_result_id,
  input wire logic [7:0] out_char,
  input wire logic [5:0] out_length,
  input wire logic       out_last
);

  // reset leaves the block quiet and ready
  `SIT_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, !rst_n, !out_valid && !busy)

  // a read-back stream runs without gaps
  `SIT_ASSERT_NEXT(a_stream_dense, clk, !rst_n, out_valid && !out_last, out_valid)

  // the id stays put across a stream
  `SIT_ASSERT_NEXT(a_stream_id, clk, !rst_n, out_valid && !out_last,
                   out_result_id == $past(out_result_id))

  // a "none" word is a single empty word
  `SIT_ASSERT_NOW(a_none_empty, clk, !rst_n, out_valid && out_result_id == 8'd0,
                  out_last && out_char == 8'd0 && out_length == 6'd0)

endmodule

bind string_intern_table sit_checker u_sit_checker (.*);
`default_nettype wire
